// File: hw/rtl/c32cmb_pkg.sv
// Package for the CRC-32 combine block: item types, the length width and
// the constant zero-byte operators. Depends on nothing; used by the
// top level.
`timescale 1ns / 1ps

package c32cmb_pkg;

    // Reflected CRC-32 polynomial and register width.
    localparam logic [31:0] CRC_POLY    = 32'hedb88320;
    localparam int          CRC_WIDTH   = 32;

    // Number of suffix length bits that take part; one pipeline stage per bit.
    localparam int          LENGTH_BITS = 64;

    // A 32x32 GF(2) matrix, one column per input bit.
    typedef logic [CRC_WIDTH-1:0][CRC_WIDTH-1:0] t_mat;

    // One operator per length bit: stage k advances the CRC by 2^k zero bytes.
    typedef t_mat [LENGTH_BITS-1:0] t_ops;

    // Multiply a matrix by a vector over GF(2).
    function automatic logic [CRC_WIDTH-1:0] gf2_apply(
        input t_mat                 mat,
        input logic [CRC_WIDTH-1:0] vec
    );
        logic [CRC_WIDTH-1:0] acc;
        acc = '0;
        for (int i = 0; i < CRC_WIDTH; i++) begin
            if (vec[i]) begin
                acc = acc ^ mat[i];
            end
        end
        return acc;
    endfunction

    // Square a matrix over GF(2).
    function automatic t_mat gf2_square(input t_mat src);
        t_mat dst;
        for (int i = 0; i < CRC_WIDTH; i++) begin
            dst[i] = gf2_apply(src, src[i]);
        end
        return dst;
    endfunction

    // Build the operator table. Start from the operator for one zero bit,
    // square three times to reach one zero byte, then square once per
    // length bit.
    function automatic t_ops build_ops();
        t_ops ops;
        t_mat op;
        op[0] = CRC_POLY;
        for (int i = 1; i < CRC_WIDTH; i++) begin
            op[i] = CRC_WIDTH'(1) << (i - 1);
        end
        for (int i = 0; i < 3; i++) begin
            op = gf2_square(op);
        end
        for (int k = 0; k < LENGTH_BITS; k++) begin
            ops[k] = op;
            op     = gf2_square(op);
        end
        return ops;
    endfunction

    localparam t_ops ZERO_OPS = build_ops();

endpackage

// File: hw/rtl/c32cmb_in_if.sv
// Request channel of the CRC-32 combine block: valid/ready handshake with
// the prefix CRC, suffix CRC and suffix length. Depends on nothing.
`timescale 1ns / 1ps

interface c32cmb_in_if;

    logic        valid;
    logic        ready;
    logic [31:0] prefix_crc;
    logic [31:0] suffix_crc;
    logic [63:0] suffix_length;

    modport source (output valid, output prefix_crc, output suffix_crc,
                    output suffix_length, input ready);
    modport sink   (input valid, input prefix_crc, input suffix_crc,
                    input suffix_length, output ready);

endinterface

// File: hw/rtl/c32cmb_out_if.sv
// Result channel of the CRC-32 combine block: valid/ready handshake with
// the combined CRC. Depends on nothing.
`timescale 1ns / 1ps

interface c32cmb_out_if;

    logic        valid;
    logic        ready;
    logic [31:0] combined_crc;

    modport source (output valid, output combined_crc, input ready);
    modport sink   (input valid, input combined_crc, output ready);

endinterface

// File: hw/rtl/crc32_combine.sv
// CRC-32 combine block, top level. Depends on c32cmb_pkg and on the
// interfaces c32cmb_in_if and c32cmb_out_if.
`timescale 1ns / 1ps

// Combines the CRC-32 of a prefix and of a suffix into the CRC-32 of the
// joined data, given the suffix length in bytes. The block is a pipeline of
// LENGTH_BITS (64) register stages, one per length bit; stage k applies the
// constant operator for 2^k zero bytes to the prefix CRC when bit k of the
// length is set. A request enters in every cycle while the pipeline is
// not held; its result appears at the last stage register. A zero length
// returns the prefix CRC unchanged. While a result waits at the output, the
// whole pipeline holds and no request is taken until the result is accepted.
module crc32_combine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    c32cmb_in_if.sink    i_req,
    c32cmb_out_if.source o_res
);

    localparam int LB = c32cmb_pkg::LENGTH_BITS;

    // Pipeline stage registers.
    logic [LB-1:0]       r_valid;
    logic [LB-1:0][31:0] r_crc;
    logic [LB-1:0][31:0] r_sfx;
    logic [LB-1:0][LB-1:0] r_len;
    logic [LB-1:0]       r_nz;

    logic [LB-1:0][31:0] n_crc;
    logic [LB-1:0][31:0] n_sfx;
    logic [LB-1:0][LB-1:0] n_len;
    logic [LB-1:0]       n_nz;
    logic [LB-1:0]       n_valid;

    logic                adv;

    // The pipeline moves as one unit whenever the last stage is empty or
    // its result is being taken. No request is taken while in reset.
    assign adv         = !r_valid[LB-1] || o_res.ready;
    assign i_req.ready = adv && i_rst_n;

    // Each stage applies its operator when its length bit is set and notes
    // whether any length bit has been seen so far.
    always_comb begin
        logic [31:0]    src_crc;
        logic [31:0]    src_sfx;
        logic [LB-1:0]  src_len;
        logic           src_nz;
        logic           src_valid;
        for (int k = 0; k < LB; k++) begin
            if (k == 0) begin
                src_crc   = i_req.prefix_crc;
                src_sfx   = i_req.suffix_crc;
                src_len   = i_req.suffix_length[LB-1:0];
                src_nz    = 1'b0;
                src_valid = i_req.valid;
            end else begin
                src_crc   = r_crc[k-1];
                src_sfx   = r_sfx[k-1];
                src_len   = r_len[k-1];
                src_nz    = r_nz[k-1];
                src_valid = r_valid[k-1];
            end
            n_crc[k]   = src_len[k]
                       ? c32cmb_pkg::gf2_apply(c32cmb_pkg::ZERO_OPS[k], src_crc)
                       : src_crc;
            n_sfx[k]   = src_sfx;
            n_len[k]   = src_len;
            n_nz[k]    = src_nz | src_len[k];
            n_valid[k] = src_valid;
        end
    end

    // Valid bits under reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (adv) begin
            r_valid <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_crc <= n_crc;
            r_sfx <= n_sfx;
            r_len <= n_len;
            r_nz  <= n_nz;
        end
    end

    // The suffix CRC is folded in only when the length was nonzero.
    assign o_res.valid        = r_valid[LB-1];
    assign o_res.combined_crc = r_nz[LB-1] ? (r_crc[LB-1] ^ r_sfx[LB-1])
                                           : r_crc[LB-1];

endmodule
